>>> hdl/nfa_sm_pkg.sv
package nfa_sm_pkg;

   localparam int NUM_STATES = 16;
   localparam int SET_W      = 16;
   localparam int STATE_W    = 4;
   localparam int SYM_W      = 8;
   localparam int ADDR_W     = STATE_W + SYM_W;
   localparam int CSR_ADDR_W = 3;

   localparam logic [SET_W-1:0] STATE_MASK =
      (NUM_STATES >= SET_W) ? {SET_W{1'b1}} : SET_W'((64'd1 << NUM_STATES) - 64'd1);

   localparam logic [SYM_W-1:0] EPSILON = '0;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_SYMBOL = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic REG_START_STATE = 1'b0;
   localparam logic REG_ACCEPT_MASK = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] from_state;
      logic [SET_W-1:0]   target_mask;
   } req_type;

   typedef struct packed {
      logic             accepted;
      logic [SET_W-1:0] final_set;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EPS_RD,
      ST_EPS_ACC,
      ST_MOV_RD,
      ST_MOV_ACC,
      ST_FINISH
   } seq_state_type;

endpackage

>>> hdl/nfa_string_matcher_unit.sv
// Thompson NFA matcher over byte strings. After reset the 4096-entry transition
// table is swept to empty, one entry per cycle, and req_ready stays low until
// the sweep ends (register writes are taken meanwhile). A load transfer writes
// its table row and leaves the block ready. A symbol transfer with a nonzero
// symbol, or an end transfer, walks the active set through the single read
// port of the table: each state visited in the epsilon closure takes a read
// step and an accumulate step (each newly reached state is visited once), then
// for a symbol each closed state is read in turn for the move. The end result
// sits in an output register; the block only stalls if a second result is
// ready before the first was taken.
module nfa_string_matcher_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  nfa_sm_pkg::req_type               req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output nfa_sm_pkg::rsp_type               rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [nfa_sm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int SET_W   = nfa_sm_pkg::SET_W;
   localparam int STATE_W = nfa_sm_pkg::STATE_W;
   localparam int SYM_W   = nfa_sm_pkg::SYM_W;
   localparam int ADDR_W  = nfa_sm_pkg::ADDR_W;
   localparam int DEPTH   = 1 << ADDR_W;

   function automatic logic [STATE_W-1:0] low_index(input logic [SET_W-1:0] v);
      logic [STATE_W-1:0] idx;
      idx = '0;
      for (int i = SET_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = STATE_W'(i);
         end
      end
      return idx;
   endfunction

   logic [SET_W-1:0] table_mem [DEPTH];

   nfa_sm_pkg::seq_state_type state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [STATE_W-1:0] start_ff, start_in;
   logic [SET_W-1:0]   accept_ff, accept_in;
   logic [SET_W-1:0]   active_ff, active_in;
   logic [SET_W-1:0]   closed_ff, closed_in;
   logic [SET_W-1:0]   pending_ff, pending_in;
   logic [SET_W-1:0]   next_ff, next_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic               is_end_ff, is_end_in;
   logic               rsp_valid_ff, rsp_valid_in;
   nfa_sm_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [SET_W-1:0]   rd_data_ff;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [SET_W-1:0]   mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [STATE_W-1:0] pick;
   logic [SET_W-1:0]   fresh;
   logic [SET_W-1:0]   start_bit;
   logic               csr_wr;
   logic               req_xfer;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign req_ready = (state_ff == nfa_sm_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign start_bit = (SET_W'(1) << start_ff) & nfa_sm_pkg::STATE_MASK;
   assign pick      = low_index(pending_ff);
   assign fresh     = rd_data_ff & nfa_sm_pkg::STATE_MASK & ~closed_ff;

   always_comb begin
      if (paddr[2] == nfa_sm_pkg::REG_ACCEPT_MASK) begin
         prdata = {{(32 - SET_W){1'b0}}, accept_ff};
      end else begin
         prdata = {{(32 - STATE_W){1'b0}}, start_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfa_sm_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         start_ff     <= '0;
         accept_ff    <= '0;
         active_ff    <= SET_W'(1) & nfa_sm_pkg::STATE_MASK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         start_ff     <= start_in;
         accept_ff    <= accept_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      closed_ff   <= closed_in;
      pending_ff  <= pending_in;
      next_ff     <= next_in;
      sym_ff      <= sym_in;
      is_end_ff   <= is_end_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      start_in     = start_ff;
      accept_in    = accept_ff;
      active_in    = active_ff;
      closed_in    = closed_ff;
      pending_in   = pending_ff;
      next_in      = next_ff;
      sym_in       = sym_ff;
      is_end_in    = is_end_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = {req_data.from_state, req_data.symbol};
      mem_wdata    = req_data.target_mask & nfa_sm_pkg::STATE_MASK;
      mem_raddr    = {pick, nfa_sm_pkg::EPSILON};

      if (csr_wr) begin
         if (paddr[2] == nfa_sm_pkg::REG_START_STATE) begin
            start_in  = pwdata[STATE_W-1:0];
            active_in = (SET_W'(1) << pwdata[STATE_W-1:0]) & nfa_sm_pkg::STATE_MASK;
         end else begin
            accept_in = pwdata[SET_W-1:0];
         end
      end

      unique case (state_ff)
         nfa_sm_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = nfa_sm_pkg::ST_IDLE;
            end
         end
         nfa_sm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               closed_in  = active_ff & nfa_sm_pkg::STATE_MASK;
               pending_in = active_ff & nfa_sm_pkg::STATE_MASK;
               sym_in     = req_data.symbol;
               is_end_in  = (req_data.kind == nfa_sm_pkg::KIND_END);
               unique case (req_data.kind)
                  nfa_sm_pkg::KIND_LOAD: begin
                     mem_we = 1'b1;
                  end
                  nfa_sm_pkg::KIND_SYMBOL: begin
                     if (req_data.symbol != nfa_sm_pkg::EPSILON) begin
                        state_in = nfa_sm_pkg::ST_EPS_RD;
                     end
                  end
                  nfa_sm_pkg::KIND_END: begin
                     state_in = nfa_sm_pkg::ST_EPS_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         nfa_sm_pkg::ST_EPS_RD: begin
            if (pending_ff == '0) begin
               if (is_end_ff) begin
                  state_in = nfa_sm_pkg::ST_FINISH;
               end else begin
                  pending_in = closed_ff;
                  next_in    = '0;
                  state_in   = nfa_sm_pkg::ST_MOV_RD;
               end
            end else begin
               pending_in = pending_ff & ~(SET_W'(1) << pick);
               state_in   = nfa_sm_pkg::ST_EPS_ACC;
            end
         end
         nfa_sm_pkg::ST_EPS_ACC: begin
            closed_in  = closed_ff | fresh;
            pending_in = pending_ff | fresh;
            state_in   = nfa_sm_pkg::ST_EPS_RD;
         end
         nfa_sm_pkg::ST_MOV_RD: begin
            mem_raddr = {pick, sym_ff};
            if (pending_ff == '0) begin
               active_in = next_ff & nfa_sm_pkg::STATE_MASK;
               state_in  = nfa_sm_pkg::ST_IDLE;
            end else begin
               pending_in = pending_ff & ~(SET_W'(1) << pick);
               state_in   = nfa_sm_pkg::ST_MOV_ACC;
            end
         end
         nfa_sm_pkg::ST_MOV_ACC: begin
            next_in  = next_ff | (rd_data_ff & nfa_sm_pkg::STATE_MASK);
            state_in = nfa_sm_pkg::ST_MOV_RD;
         end
         nfa_sm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.accepted  = ((closed_ff & accept_ff) != '0);
               rsp_data_in.final_set = closed_ff;
               active_in             = start_bit;
               state_in              = nfa_sm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nfa_sm_pkg::ST_IDLE;
         end
      endcase
   end

   // closure work list only ever holds states already in the closed set
   a_pending_in_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nfa_sm_pkg::ST_EPS_RD || state_ff == nfa_sm_pkg::ST_EPS_ACC)
      |-> ((pending_ff & ~closed_ff) == '0))
      else $error("pending state outside closed set");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == nfa_sm_pkg::ST_FINISH))
      else $error("result raised outside finish");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != nfa_sm_pkg::ST_CLEAR) |=> (state_ff != nfa_sm_pkg::ST_CLEAR))
      else $error("clearing pass re-entered");

   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_data.kind == nfa_sm_pkg::KIND_END) |=> !req_ready)
      else $error("ready while end transfer in progress");

   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result dropped or changed");

endmodule

>>> bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_W   = nfa_sm_pkg::SET_W;
   localparam int STATE_W = nfa_sm_pkg::STATE_W;
   localparam int SYM_W   = nfa_sm_pkg::SYM_W;
   localparam int ADDR_W  = nfa_sm_pkg::ADDR_W;
   localparam int CSR_ADDR_W = nfa_sm_pkg::CSR_ADDR_W;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 212;
   localparam int IDLE_LIMIT = 25000;
   localparam int DRAIN_CYCLES = 80;
   localparam int LONG_HOLD = 300;

   class match_tracker;
      logic [SET_W-1:0]    rows [1 << ADDR_W];
      logic [SET_W-1:0]    active;
      logic [STATE_W-1:0]  start_idx;
      logic [SET_W-1:0]    accept_bits;
      nfa_sm_pkg::rsp_type expected_matches [$];
      int                  errors;

      function new();
         foreach (rows[i]) rows[i] = '0;
         start_idx   = '0;
         accept_bits = '0;
         errors      = 0;
         active      = start_bit();
      endfunction

      function logic [SET_W-1:0] start_bit();
         return (SET_W'(1) << start_idx) & nfa_sm_pkg::STATE_MASK;
      endfunction

      function logic [SET_W-1:0] eps_closure(logic [SET_W-1:0] set_in);
         logic [SET_W-1:0] cur;
         logic [SET_W-1:0] prev;
         int i;
         cur = set_in & nfa_sm_pkg::STATE_MASK;
         do begin
            prev = cur;
            for (i = 0; i < SET_W; i++)
               if (prev[i]) cur |= rows[{STATE_W'(i), nfa_sm_pkg::EPSILON}];
            cur &= nfa_sm_pkg::STATE_MASK;
         end while (cur != prev);
         return cur;
      endfunction

      function void write_reg(logic idx, logic [31:0] val);
         if (idx == nfa_sm_pkg::REG_START_STATE) begin
            start_idx = val[STATE_W-1:0];
            active    = start_bit();
         end else begin
            accept_bits = val[SET_W-1:0];
         end
      endfunction

      function void note_transfer(nfa_sm_pkg::req_type it);
         logic [SET_W-1:0]    closed;
         logic [SET_W-1:0]    moved;
         nfa_sm_pkg::rsp_type want;
         int                  i;
         case (it.kind)
            nfa_sm_pkg::KIND_LOAD: begin
               rows[{it.from_state, it.symbol}] = it.target_mask & nfa_sm_pkg::STATE_MASK;
            end
            nfa_sm_pkg::KIND_SYMBOL: begin
               if (it.symbol != nfa_sm_pkg::EPSILON) begin
                  closed = eps_closure(active);
                  moved  = '0;
                  for (i = 0; i < SET_W; i++)
                     if (closed[i]) moved |= rows[{STATE_W'(i), it.symbol}];
                  active = moved & nfa_sm_pkg::STATE_MASK;
               end
            end
            nfa_sm_pkg::KIND_END: begin
               closed         = eps_closure(active);
               want.accepted  = |(closed & accept_bits);
               want.final_set = closed;
               expected_matches.push_back(want);
               active = start_bit();
            end
            default: ;
         endcase
      endfunction

      function void check_result(nfa_sm_pkg::rsp_type got);
         nfa_sm_pkg::rsp_type want;
         if (expected_matches.size() == 0) begin
            $error("unexpected result transfer: accepted %0b final_set %h",
                   got.accepted, got.final_set);
            errors++;
            return;
         end
         want = expected_matches.pop_front();
         if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0b, actual %0b", want.accepted, got.accepted);
            errors++;
         end
         if (got.final_set !== want.final_set) begin
            $error("final_set: expected %h, actual %h", want.final_set, got.final_set);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   nfa_sm_pkg::req_type   req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   nfa_sm_pkg::rsp_type   rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   match_tracker       tracker;
   logic [STATE_W-1:0] state_pool [5];
   logic [SYM_W-1:0]   alphabet [3];
   logic [STATE_W-1:0] cur_start = '0;
   bit                 tx_burst = 1'b0;
   int                 sent = 0;
   int                 idle_cycles = 0;

   nfa_string_matcher_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_data);
         if (req_valid && req_ready) tracker.note_transfer(req_data);
         if (psel && penable && pwrite && pready)
            tracker.write_reg(paddr[CSR_ADDR_W-1], pwdata);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random hold-off per transfer, two long stalls to back up the block
   initial begin
      int hold;
      int taken;
      bit burst;
      taken = 0;
      burst = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) burst = !burst;
         hold = burst ? 0 : $urandom_range(0, 12);
         if (taken == 30 || taken == 150) hold = LONG_HOLD;
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   function automatic nfa_sm_pkg::req_type make_item(logic [1:0] k, logic [SYM_W-1:0] s,
                                                     logic [STATE_W-1:0] f,
                                                     logic [SET_W-1:0] m);
      nfa_sm_pkg::req_type it;
      it.kind        = k;
      it.symbol      = s;
      it.from_state  = f;
      it.target_mask = m;
      return it;
   endfunction

   function automatic logic [SET_W-1:0] pick_targets();
      logic [SET_W-1:0] t;
      if ($urandom_range(0, 7) == 0) return SET_W'($urandom);
      t = SET_W'(1) << state_pool[$urandom_range(0, 4)];
      if ($urandom_range(0, 1) == 1) t |= SET_W'(1) << state_pool[$urandom_range(0, 4)];
      return t;
   endfunction

   function automatic logic [SYM_W-1:0] pick_symbol();
      if ($urandom_range(0, 15) == 0) return SYM_W'($urandom);
      return alphabet[$urandom_range(0, 2)];
   endfunction

   function automatic nfa_sm_pkg::req_type noise_item();
      case ($urandom_range(0, 3))
         0: return make_item(KIND_UNUSED, SYM_W'($urandom), STATE_W'($urandom),
                             SET_W'($urandom));
         1: return make_item(nfa_sm_pkg::KIND_SYMBOL, nfa_sm_pkg::EPSILON,
                             STATE_W'($urandom), SET_W'($urandom));
         2: return make_item(nfa_sm_pkg::KIND_LOAD, SYM_W'($urandom), STATE_W'($urandom),
                             SET_W'($urandom));
         default: return make_item(nfa_sm_pkg::KIND_SYMBOL, SYM_W'($urandom),
                                   STATE_W'($urandom), SET_W'($urandom));
      endcase
   endfunction

   task automatic send_item(nfa_sm_pkg::req_type it);
      int gap;
      if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (it.kind != KIND_UNUSED &&
          !(it.kind == nfa_sm_pkg::KIND_SYMBOL && it.symbol == nfa_sm_pkg::EPSILON))
         sent++;
   endtask

   task automatic csr_write(logic idx, logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_block();
      @(posedge clock);
      while (tracker.expected_matches.size() != 0 || rsp_valid || !req_ready)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // small automata over a few states and symbols, then strings run through them
   task automatic random_phase(int quota);
      int stop_at;
      int len;
      int k;
      stop_at = sent + quota;
      while (sent < stop_at) begin
         state_pool[0] = cur_start;
         for (k = 1; k < 5; k++) state_pool[k] = STATE_W'($urandom);
         for (k = 0; k < 3; k++) alphabet[k] = SYM_W'($urandom_range(1, 255));
         repeat ($urandom_range(4, 12))
            send_item(make_item(nfa_sm_pkg::KIND_LOAD,
                                ($urandom_range(0, 2) == 0) ? nfa_sm_pkg::EPSILON
                                                            : alphabet[$urandom_range(0, 2)],
                                state_pool[$urandom_range(0, 4)], pick_targets()));
         repeat ($urandom_range(2, 6)) begin
            len = $urandom_range(0, 6);
            repeat (len)
               send_item(make_item(nfa_sm_pkg::KIND_SYMBOL, pick_symbol(),
                                   STATE_W'($urandom), SET_W'($urandom)));
            if ($urandom_range(0, 5) == 0) send_item(noise_item());
            send_item(make_item(nfa_sm_pkg::KIND_END, SYM_W'($urandom), STATE_W'($urandom),
                                SET_W'($urandom)));
         end
      end
   endtask

   initial begin
      int               phase;
      logic [31:0]      accept_val;
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      csr_write(nfa_sm_pkg::REG_START_STATE, 32'd0);
      csr_write(nfa_sm_pkg::REG_ACCEPT_MASK, 32'h0000_8001);
      cur_start = '0;

      send_item(make_item(nfa_sm_pkg::KIND_LOAD, 8'hff, 4'hf, 16'hffff));
      send_item(make_item(nfa_sm_pkg::KIND_LOAD, nfa_sm_pkg::EPSILON, 4'h0, 16'h0002));
      send_item(make_item(nfa_sm_pkg::KIND_LOAD, 8'h61, 4'h1, 16'h0004));
      send_item(make_item(nfa_sm_pkg::KIND_LOAD, 8'hff, 4'h2, 16'h8000));
      send_item(make_item(nfa_sm_pkg::KIND_LOAD, nfa_sm_pkg::EPSILON, 4'hf, 16'h0001));
      send_item(make_item(nfa_sm_pkg::KIND_END, 8'h00, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_SYMBOL, 8'h61, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_SYMBOL, nfa_sm_pkg::EPSILON, 4'hf, 16'hffff));
      send_item(make_item(KIND_UNUSED, 8'hff, 4'hf, 16'hffff));
      send_item(make_item(nfa_sm_pkg::KIND_SYMBOL, 8'hff, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_END, 8'hff, 4'hf, 16'hffff));
      send_item(make_item(nfa_sm_pkg::KIND_SYMBOL, 8'hff, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_SYMBOL, 8'hff, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_END, 8'h00, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_LOAD, nfa_sm_pkg::EPSILON, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_LOAD, 8'h80, 4'h0, 16'hffff));
      send_item(make_item(nfa_sm_pkg::KIND_SYMBOL, 8'h80, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_SYMBOL, 8'hff, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_END, 8'h00, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_END, 8'h00, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_SYMBOL, 8'h01, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_END, 8'h00, 4'h0, 16'h0000));
      send_item(make_item(nfa_sm_pkg::KIND_LOAD, nfa_sm_pkg::EPSILON, 4'hf, 16'h0000));

      random_phase(ITEMS_PER_PHASE);

      for (phase = 1; phase < PHASES; phase++) begin
         req_valid <= 1'b0;
         drain_block();
         case (phase)
            1: begin
               cur_start  = 4'hf;
               accept_val = 32'h0000_ffff;
            end
            2: begin
               cur_start  = 4'h0;
               accept_val = 32'h0000_0000;
            end
            default: begin
               cur_start  = STATE_W'($urandom);
               accept_val = $urandom;
            end
         endcase
         csr_write(nfa_sm_pkg::REG_START_STATE, 32'(cur_start));
         csr_write(nfa_sm_pkg::REG_ACCEPT_MASK, accept_val);
         random_phase(ITEMS_PER_PHASE);
      end

      req_valid <= 1'b0;
      drain_block();
      if (tracker.errors == 0 && tracker.expected_matches.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> nfa_string_matcher_unit.f
hdl/nfa_sm_pkg.sv
hdl/nfa_string_matcher_unit.sv
bench/tb_top.sv
